// ----- hw/rtl/lmv_pkg.sv -----
`timescale 1ns / 1ps
package lmv_pkg;

  localparam int MomentumBitsDefault = 18;
  localparam int RegW = 14;
  localparam int MsqW = 2 * RegW;
  localparam int NumStages = 8;

  localparam logic [RegW-1:0] ProtonMassReset = RegW'(3843);
  localparam logic [RegW-1:0] PionMassReset   = RegW'(572);
  localparam logic [RegW-1:0] WindowLowReset  = RegW'(4547);
  localparam logic [RegW-1:0] WindowHighReset = RegW'(4608);

  typedef enum logic [1:0] {
    RegProtonMass = 2'd0,
    RegPionMass   = 2'd1,
    RegWindowLow  = 2'd2,
    RegWindowHigh = 2'd3
  } reg_idx_e;

  // Squares of the configuration registers.
  typedef struct packed {
    logic [MsqW-1:0] proton_sq;
    logic [MsqW-1:0] pion_sq;
    logic [MsqW-1:0] low_sq;
    logic [MsqW-1:0] high_sq;
  } msq_t;

  // Per-item flags that ride along with the wide products.
  typedef struct packed {
    logic plus_proton;
    logic r_pos;
    logic q_neg;
  } side_t;

  function automatic int max_w(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Sum of three squares of a p-bit signed value.
  function automatic int sum_w(input int p);
    return 2 * p + 1;
  endfunction

  // Squared magnitude plus a squared mass.
  function automatic int ab_w(input int p);
    return max_w(sum_w(p), MsqW) + 1;
  endfunction

  // Signed dot product of two p-bit vectors.
  function automatic int dot_w(input int p);
    return 2 * p + 2;
  endfunction

  // Signed right-hand side of the window compares.
  function automatic int r_w(input int p);
    return max_w(dot_w(p) + 1, MsqW + 1) + 3;
  endfunction

  function automatic int mul_w(input int p);
    return max_w(ab_w(p), r_w(p));
  endfunction

endpackage

// ----- hw/rtl/lmv_cfg.sv -----
`timescale 1ns / 1ps
module lmv_cfg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [lmv_pkg::RegW-1:0] cfg_data_i,
  output lmv_pkg::msq_t          msq_o
);
  import lmv_pkg::*;

  logic [RegW-1:0] proton_q, pion_q, low_q, high_q;
  msq_t            msq_q, msq_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proton_q <= ProtonMassReset;
      pion_q   <= PionMassReset;
      low_q    <= WindowLowReset;
      high_q   <= WindowHighReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegProtonMass: proton_q <= cfg_data_i;
        RegPionMass:   pion_q   <= cfg_data_i;
        RegWindowLow:  low_q    <= cfg_data_i;
        RegWindowHigh: high_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    msq_d.proton_sq = MsqW'(proton_q) * MsqW'(proton_q);
    msq_d.pion_sq   = MsqW'(pion_q) * MsqW'(pion_q);
    msq_d.low_sq    = MsqW'(low_q) * MsqW'(low_q);
    msq_d.high_sq   = MsqW'(high_q) * MsqW'(high_q);
  end

  // Squares are refreshed every cycle; the user must change registers only while idle, unchecked by the block.
  always_ff @(posedge clk_i) begin
    msq_q <= msq_d;
  end

  assign msq_o = msq_q;

endmodule

// ----- hw/rtl/lmv_front.sv -----
`timescale 1ns / 1ps
module lmv_front #(
  parameter int MomentumBits = lmv_pkg::MomentumBitsDefault
) (
  input  logic                                   clk_i,
  input  logic [3:0]                             en_i,
  input  lmv_pkg::msq_t                          msq_i,
  input  logic signed [MomentumBits-1:0]         pp_i [3],
  input  logic signed [MomentumBits-1:0]         pm_i [3],
  output logic [lmv_pkg::ab_w(MomentumBits)-1:0] a_o,
  output logic [lmv_pkg::ab_w(MomentumBits)-1:0] b_o,
  output logic [lmv_pkg::r_w(MomentumBits)-1:0]  rmag_o,
  output logic [lmv_pkg::r_w(MomentumBits)-1:0]  qmag_o,
  output lmv_pkg::side_t                         side_o
);
  import lmv_pkg::*;

  localparam int SqW  = 2 * MomentumBits;
  localparam int SumW = sum_w(MomentumBits);
  localparam int AbW  = ab_w(MomentumBits);
  localparam int DotW = dot_w(MomentumBits);
  localparam int RW   = r_w(MomentumBits);

  logic signed [SqW-1:0] pe [3];
  logic signed [SqW-1:0] me [3];
  logic [SqW-1:0]        sqp_q [3];
  logic [SqW-1:0]        sqm_q [3];
  logic signed [SqW-1:0] x_q [3];

  logic [SumW-1:0]        sp_q, sm_q;
  logic signed [DotW-1:0] dot_q;

  logic                 pp_gt;
  logic [AbW-1:0]       a2_d, b2_d, a2_q, b2_q, a3_q, b3_q;
  logic signed [RW-1:0] base, r_d, q_d, r_q, q_q;
  logic                 pp2_q;
  logic [RW-1:0]        rmag_q, qmag_q;
  side_t                side_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pe[i] = SqW'(pp_i[i]);
      me[i] = SqW'(pm_i[i]);
    end
  end

  // Stage 0: component squares and cross products.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 3; i++) begin
        sqp_q[i] <= pe[i] * pe[i];
        sqm_q[i] <= me[i] * me[i];
        x_q[i]   <= pe[i] * me[i];
      end
    end
  end

  // Stage 1: squared magnitudes and the dot product.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sp_q  <= SumW'(sqp_q[0]) + SumW'(sqp_q[1]) + SumW'(sqp_q[2]);
      sm_q  <= SumW'(sqm_q[0]) + SumW'(sqm_q[1]) + SumW'(sqm_q[2]);
      dot_q <= DotW'(x_q[0]) + DotW'(x_q[1]) + DotW'(x_q[2]);
    end
  end

  // Stage 2: mass assignment and the two window right-hand sides.
  always_comb begin
    pp_gt = sp_q > sm_q;
    if (pp_gt) begin
      a2_d = AbW'(sp_q) + AbW'(msq_i.proton_sq);
      b2_d = AbW'(sm_q) + AbW'(msq_i.pion_sq);
    end else begin
      a2_d = AbW'(sm_q) + AbW'(msq_i.proton_sq);
      b2_d = AbW'(sp_q) + AbW'(msq_i.pion_sq);
    end
    base = (RW'(dot_q) <<< 1) - RW'(msq_i.proton_sq) - RW'(msq_i.pion_sq);
    r_d  = base + RW'(msq_i.low_sq);
    q_d  = base + RW'(msq_i.high_sq);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      a2_q  <= a2_d;
      b2_q  <= b2_d;
      r_q   <= r_d;
      q_q   <= q_d;
      pp2_q <= pp_gt;
    end
  end

  // Stage 3: signs, the magnitude of R and the raw Q for the squaring multipliers.
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      a3_q               <= a2_q;
      b3_q               <= b2_q;
      rmag_q             <= r_q[RW-1] ? RW'(-r_q) : RW'(r_q);
      qmag_q             <= RW'(q_q);
      side_q.plus_proton <= pp2_q;
      side_q.r_pos       <= !r_q[RW-1] && (r_q != '0);
      side_q.q_neg       <= q_q[RW-1];
    end
  end

  assign a_o    = a3_q;
  assign b_o    = b3_q;
  assign rmag_o = rmag_q;
  assign qmag_o = qmag_q;
  assign side_o = side_q;

endmodule

// ----- hw/rtl/lmv_mul.sv -----
`timescale 1ns / 1ps
module lmv_mul #(
  parameter int W = 42
) (
  input  logic             clk_i,
  input  logic [2:0]       en_i,
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     b_i,
  output logic [2*W-1:0]   prod_o
);

  localparam int LimbW = 32;
  localparam int NumLimbs = (W + LimbW - 1) / LimbW;
  localparam int PadW = NumLimbs * LimbW;

  logic [PadW-1:0]    a_pad, b_pad;
  logic [2*LimbW-1:0] pp_q [NumLimbs][NumLimbs];
  logic [2*PadW-1:0]  row_d [NumLimbs];
  logic [2*PadW-1:0]  row_q [NumLimbs];
  logic [2*PadW-1:0]  total_d, prod_q;

  assign a_pad = PadW'(a_i);
  assign b_pad = PadW'(b_i);

  // Limb partial products, each at most 32 by 32 bits.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < NumLimbs; i++) begin
        for (int j = 0; j < NumLimbs; j++) begin
          pp_q[i][j] <= (2*LimbW)'(a_pad[i*LimbW +: LimbW]) *
                        (2*LimbW)'(b_pad[j*LimbW +: LimbW]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NumLimbs; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NumLimbs; j++) begin
        row_d[i] = row_d[i] + ((2*PadW)'(pp_q[i][j]) << (j * LimbW));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      row_q <= row_d;
    end
  end

  always_comb begin
    total_d = '0;
    for (int i = 0; i < NumLimbs; i++) begin
      total_d = total_d + (row_q[i] << (i * LimbW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      prod_q <= total_d;
    end
  end

  assign prod_o = prod_q[2*W-1:0];

endmodule

// ----- hw/rtl/lambda_mass_veto.sv -----
`timescale 1ns / 1ps
// Two-track invariant-mass window veto. Each item carries the momenta of a
// positive and a negative track; the block assigns the proton mass to the
// track with the larger momentum (the negative track on a tie), forms the
// pair mass and flags it when it lies below window_low or above window_high.
// All compares are exact, done on squares with no rounding. The datapath is
// an eight-stage pipeline: component products, magnitude and dot sums, mass
// assignment, sign and magnitude, then three wide multipliers that each take
// three stages (32-bit limb products, row sums, final sum), and a last compare
// stage that is also the output register. One item is accepted every cycle
// unless an output stall has filled the pipeline. Stalls ripple back stage
// by stage, so bubbles are squeezed out and new items keep entering while
// a finished result waits. Configuration registers take effect for items
// accepted after the write.
module lambda_mass_veto #(
  parameter int MomentumBits = lmv_pkg::MomentumBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [lmv_pkg::RegW-1:0]       cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [MomentumBits-1:0] plus_px_i,
  input  logic signed [MomentumBits-1:0] plus_py_i,
  input  logic signed [MomentumBits-1:0] plus_pz_i,
  input  logic signed [MomentumBits-1:0] minus_px_i,
  input  logic signed [MomentumBits-1:0] minus_py_i,
  input  logic signed [MomentumBits-1:0] minus_pz_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           outside_window_o,
  output logic                           plus_is_proton_o
);
  import lmv_pkg::*;

  localparam int AbW  = ab_w(MomentumBits);
  localparam int RW   = r_w(MomentumBits);
  localparam int MulW = mul_w(MomentumBits);
  localparam int CmpW = 2 * MulW + 2;

  msq_t msq;

  // Stage enables: a stage loads when it is empty or its successor moves.
  logic [NumStages-1:0] en;
  logic [NumStages-1:0] v_q, v_d;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o = en[0];

  lmv_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .msq_o      (msq)
  );

  logic signed [MomentumBits-1:0] pp [3];
  logic signed [MomentumBits-1:0] pm [3];
  logic [AbW-1:0] a, b;
  logic [RW-1:0]  rmag, qmag;
  side_t          side3;

  assign pp[0] = plus_px_i;
  assign pp[1] = plus_py_i;
  assign pp[2] = plus_pz_i;
  assign pm[0] = minus_px_i;
  assign pm[1] = minus_py_i;
  assign pm[2] = minus_pz_i;

  lmv_front #(
    .MomentumBits (MomentumBits)
  ) u_front (
    .clk_i  (clk_i),
    .en_i   (en[3:0]),
    .msq_i  (msq),
    .pp_i   (pp),
    .pm_i   (pm),
    .a_o    (a),
    .b_o    (b),
    .rmag_o (rmag),
    .qmag_o (qmag),
    .side_o (side3)
  );

  logic [2*MulW-1:0] ab, r2, q2;

  lmv_mul #(.W(MulW)) u_mul_ab (
    .clk_i  (clk_i),
    .en_i   (en[6:4]),
    .a_i    (MulW'(a)),
    .b_i    (MulW'(b)),
    .prod_o (ab)
  );

  lmv_mul #(.W(MulW)) u_mul_r (
    .clk_i  (clk_i),
    .en_i   (en[6:4]),
    .a_i    (MulW'(rmag)),
    .b_i    (MulW'(rmag)),
    .prod_o (r2)
  );

  lmv_mul #(.W(MulW)) u_mul_q (
    .clk_i  (clk_i),
    .en_i   (en[6:4]),
    .a_i    (MulW'(qmag)),
    .b_i    (MulW'(qmag)),
    .prod_o (q2)
  );

  // The flags follow the multiplier stages.
  side_t side_q [3];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      side_q[0] <= side3;
    end
    if (en[5]) begin
      side_q[1] <= side_q[0];
    end
    if (en[6]) begin
      side_q[2] <= side_q[1];
    end
  end

  // Final stage: the mass is below the window when 2*E1*E2 < R, which for
  // positive R is 4AB < R^2; it is above when 2*E1*E2 > Q, which holds for
  // any negative Q and otherwise is Q^2 < 4AB.
  logic [CmpW-1:0] four_ab;
  logic            below, above;
  logic            outside_q, proton_q;

  always_comb begin
    four_ab = CmpW'(ab) << 2;
    below   = side_q[2].r_pos && (four_ab < CmpW'(r2));
    above   = side_q[2].q_neg || (CmpW'(q2) < four_ab);
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      outside_q <= below || above;
      proton_q  <= side_q[2].plus_proton;
    end
  end

  assign out_valid_o      = v_q[NumStages-1];
  assign outside_window_o = outside_q;
  assign plus_is_proton_o = proton_q;

endmodule

// ----- hw/rtl/lmv_checker.sv -----
`timescale 1ns / 1ps
module lmv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic outside_window_o,
  input logic plus_is_proton_o
);

  // The pipeline only refuses input when the output is held up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without an output stall");

  // Nothing comes out once reset has been applied at a clock edge.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result shown during reset");

  // A result that is not taken stays presented.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      ($stable(outside_window_o) && $stable(plus_is_proton_o)))
    else $error("result changed while stalled");

endmodule

bind lambda_mass_veto lmv_checker u_lmv_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import lmv_pkg::*;

  localparam int PW = MomentumBitsDefault;
  localparam int CycleLimit = 400000;

  typedef struct {
    logic signed [PW-1:0] ppx, ppy, ppz, mpx, mpy, mpz;
  } pair_t;

  typedef struct {
    logic outside;
    logic plus_proton;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [RegW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [PW-1:0] plus_px_i = '0, plus_py_i = '0, plus_pz_i = '0;
  logic signed [PW-1:0] minus_px_i = '0, minus_py_i = '0, minus_pz_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic outside_window_o, plus_is_proton_o;

  lambda_mass_veto #(.MomentumBits(PW)) u_dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Local copy of the mass hypotheses and window edges.
  logic [RegW-1:0] m_proton = ProtonMassReset, m_pion = PionMassReset;
  logic [RegW-1:0] edge_lo = WindowLowReset, edge_hi = WindowHighReset;

  pair_t pending_pairs[$];
  verdict_t expected_verdicts[$];
  int errors = 0, n_sent = 0, n_checked = 0, n_vetoed = 0, n_plus_proton = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;

  // Exact veto decision on squares. 160-bit signed arithmetic covers every
  // product the compares need with room to spare.
  function automatic verdict_t predict_veto(pair_t p);
    logic signed [159:0] sp, sm, a, b, dot, base, four_ab, r, q, mp2, mq2;
    verdict_t v;
    logic below, above;
    sp = 160'(p.ppx) * 160'(p.ppx) + 160'(p.ppy) * 160'(p.ppy)
       + 160'(p.ppz) * 160'(p.ppz);
    sm = 160'(p.mpx) * 160'(p.mpx) + 160'(p.mpy) * 160'(p.mpy)
       + 160'(p.mpz) * 160'(p.mpz);
    mp2 = $signed({146'd0, m_proton}) * $signed({146'd0, m_proton});
    mq2 = $signed({146'd0, m_pion}) * $signed({146'd0, m_pion});
    v.plus_proton = sp > sm;
    a = (v.plus_proton ? sp : sm) + mp2;
    b = (v.plus_proton ? sm : sp) + mq2;
    dot = 160'(p.ppx) * 160'(p.mpx) + 160'(p.ppy) * 160'(p.mpy)
        + 160'(p.ppz) * 160'(p.mpz);
    base = 2 * dot - mp2 - mq2;
    four_ab = 4 * a * b;
    r = base + $signed({146'd0, edge_lo}) * $signed({146'd0, edge_lo});
    below = (r > 0) && (four_ab < r * r);
    q = base + $signed({146'd0, edge_hi}) * $signed({146'd0, edge_hi});
    above = (q < 0) || (q * q < four_ab);
    v.outside = below | above;
    return v;
  endfunction

  function automatic logic signed [PW-1:0] rand_mom(int mode);
    case (mode)
      0: return PW'($urandom);
      1: return PW'($signed($urandom_range(0, 16000)) - 8000);
      default: return PW'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int mode;
    mode = $urandom_range(0, 2);
    p = '{rand_mom(mode), rand_mom(mode), rand_mom(mode),
          rand_mom(mode), rand_mom(mode), rand_mom(mode)};
    // Sometimes mirror magnitudes to hit the tie case.
    if ($urandom_range(0, 15) == 0) begin
      p.mpx = -p.ppx;
      p.mpy = p.ppy;
      p.mpz = p.ppz;
    end
    return p;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [RegW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegProtonMass: m_proton = val;
      RegPionMass: m_pion = val;
      RegWindowLow: edge_lo = val;
      default: edge_hi = val;
    endcase
  endtask

  task automatic wait_drained();
    wait (pending_pairs.size() == 0 && !in_valid_i);
    wait (expected_verdicts.size() == 0);
    repeat (NumStages + 4) @(negedge clk_i);
  endtask

  localparam logic signed [PW-1:0] PMax = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] PMin = {1'b1, {(PW-1){1'b0}}};

  // Acceptance: predict at the edge where the item is taken.
  logic accepted_q = 1'b0;
  always @(posedge clk_i) begin
    pair_t p;
    accepted_q <= 1'b0;
    if (rst_ni && in_valid_i && in_ready_o) begin
      p = '{plus_px_i, plus_py_i, plus_pz_i, minus_px_i, minus_py_i, minus_pz_i};
      expected_verdicts.push_back(predict_veto(p));
      accepted_q <= 1'b1;
      n_sent++;
    end
  end

  // Driver: one item at a time from the pending queue, random gaps.
  int send_gap = 0;
  always @(negedge clk_i) begin
    pair_t p;
    if (rst_ni) begin
      if (in_valid_i && !accepted_q) begin
        // Still offering the same item.
      end else if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_pairs.size() > 0) begin
        p = pending_pairs.pop_front();
        in_valid_i <= 1'b1;
        {plus_px_i, plus_py_i, plus_pz_i} <= {p.ppx, p.ppy, p.ppz};
        {minus_px_i, minus_py_i, minus_pz_i} <= {p.mpx, p.mpy, p.mpz};
        if ($urandom_range(0, 3) == 0)
          send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                  : $urandom_range(1, 2);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, and one long hold-off on request.
  int recv_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        out_ready_i <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 4) == 0)
          recv_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                  : $urandom_range(1, 2);
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    verdict_t v;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result item");
        errors++;
      end else begin
        v = expected_verdicts.pop_front();
        if (outside_window_o !== v.outside) begin
          $error("outside_window expected %0b actual %0b", v.outside, outside_window_o);
          errors++;
        end
        if (plus_is_proton_o !== v.plus_proton) begin
          $error("plus_is_proton expected %0b actual %0b", v.plus_proton,
                 plus_is_proton_o);
          errors++;
        end
        n_checked++;
        n_vetoed += v.outside;
        n_plus_proton += v.plus_proton;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) pending_pairs.push_back(rand_pair());
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, ties, zero momenta, real lambda-like pairs.
    pending_pairs.push_back('{0, 0, 0, 0, 0, 0});
    pending_pairs.push_back('{PMax, PMax, PMax, PMin, PMin, PMin});
    pending_pairs.push_back('{PMin, PMin, PMin, PMax, PMax, PMax});
    pending_pairs.push_back('{PMin, PMin, PMin, PMin, PMin, PMin});
    pending_pairs.push_back('{PMax, 0, 0, PMin, 0, 0});
    pending_pairs.push_back('{-1, -1, -1, 1, 1, 1});
    pending_pairs.push_back('{100, 0, 0, 0, 100, 0});
    pending_pairs.push_back('{4000, 0, 0, 700, 0, 0});
    pending_pairs.push_back('{0, 0, 4000, 0, 0, -700});
    pending_pairs.push_back('{600, 300, 2000, 50, 100, 300});
    pending_pairs.push_back('{PMax, PMax, PMax, PMax, PMax, PMax});
    pending_pairs.push_back('{1, 0, 0, 0, 0, 0});
    queue_random(300);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering items.
    queue_random(200);
    hold_off = 1'b1;
    repeat (200) @(negedge clk_i);
    hold_off = 1'b0;
    wait_drained();

    // Extreme and inverted settings, zero masses and edges.
    write_reg(RegProtonMass, '1);
    write_reg(RegPionMass, '0);
    write_reg(RegWindowLow, '0);
    write_reg(RegWindowHigh, '1);
    queue_random(300);
    wait_drained();
    write_reg(RegProtonMass, '0);
    write_reg(RegPionMass, '1);
    write_reg(RegWindowLow, '1);
    write_reg(RegWindowHigh, '0);
    queue_random(300);
    wait_drained();
    write_reg(RegProtonMass, '0);
    write_reg(RegPionMass, '0);
    write_reg(RegWindowLow, 14'd0);
    write_reg(RegWindowHigh, 14'd0);
    pending_pairs.push_back('{0, 0, 0, 0, 0, 0});
    pending_pairs.push_back('{5, 0, 0, 5, 0, 0});
    queue_random(200);
    wait_drained();
    for (int k = 0; k < 2; k++) begin
      write_reg(RegProtonMass, RegW'($urandom));
      write_reg(RegPionMass, RegW'($urandom));
      write_reg(RegWindowLow, RegW'($urandom_range(0, 8000)));
      write_reg(RegWindowHigh, RegW'($urandom));
      queue_random(350);
      wait_drained();
    end

    $display("Checked %0d of %0d items: %0d vetoed, %0d with the positive proton.",
             n_checked, n_sent, n_vetoed, n_plus_proton);
    $display("Covered default, extreme, inverted, zero and random mass settings.");
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- lambda_mass_veto.f -----
hw/rtl/lmv_pkg.sv
hw/rtl/lmv_cfg.sv
hw/rtl/lmv_front.sv
hw/rtl/lmv_mul.sv
hw/rtl/lambda_mass_veto.sv
hw/rtl/lmv_checker.sv
sim/tb.sv
